>>> hw/rtl/wspf_pkg.sv
// Package for the wheel speed frame parser.
// Holds frame control codes, sizes and shared types; no dependencies.
`default_nettype none

package wspf_pkg;

    localparam int KEPT_BYTES  = 9;
    localparam int SPEED_W     = 17;
    localparam int NUM_SPEEDS  = 4;
    localparam int OUT_DATA_W  = 72;

    localparam logic [7:0] CH_CLOSE  = 8'h3B;
    localparam logic [7:0] CH_ABORT  = 8'h25;
    localparam logic [7:0] CH_OPEN_A = 8'h2A;
    localparam logic [7:0] CH_OPEN_B = 8'h23;

    localparam logic [16:0] SIGN_OFFSET = 17'd65535;

    localparam logic [7:0]  WHEEL_CODE_RST = 8'd1;
    localparam logic [15:0] THRESH_RST     = 16'd20000;

    typedef enum logic {
        ACT_BYTE = 1'b0,
        ACT_IDLE = 1'b1
    } action_t;

    typedef enum logic {
        REG_WHEEL_CODE = 1'b0,
        REG_THRESHOLD  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic clear;
        logic store;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/wheel_speed_frame_parser.sv
// Top level of the wheel speed frame parser: cell chain, decode, output register.
// Depends on wspf_pkg, wspf_cell and wspf_speed.
//
// Usage:
//   s_ channel carries one transaction per received byte (s_tuser = 0) or
//   line-idle event (s_tuser = 1). '*' or '#' opens a frame; the type byte
//   and eight payload bytes are kept in a chain of nine byte cells, later
//   bytes are dropped. ';' closes the frame and, if the type byte matches
//   wheel_type_code, one m_ transaction carries four signed 17-bit speeds.
//   '%' aborts. After ';' or '%' bytes are ignored until the next idle event.
//   A result appears in the cycle after the closing byte is accepted.
//   Throughput: one input transaction per cycle while s_tready is high; the
//   speed decode is combinational on the cell outputs and the result
//   register loads at the edge that accepts the closing byte.
//   When the receiver stalls with a result held, s_tready follows m_tready,
//   so at most one result waits and none is lost.
//   Reset (aresetn low, synchronous) clears the buffer and frame state and
//   loads wheel_type_code = 1, sign_threshold = 20000. Configuration writes
//   (cfg_wr_en, cfg_index, cfg_data) take effect at the next edge.
`default_nettype none

module wheel_speed_frame_parser (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire         cfg_index,
    input  wire  [15:0] cfg_data,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire         s_tuser,   // [0] action
    output logic        m_tvalid,
    input  wire         m_tready,
    // [16:0] speed_one, [33:17] speed_two, [50:34] speed_three,
    // [67:51] speed_four, [71:68] zero
    output logic [71:0] m_tdata
);
    import wspf_pkg::*;

    logic [7:0]  wheel_code_reg;
    logic [15:0] threshold_reg;
    logic        in_frame_reg;
    logic        in_frame_next;
    logic        skip_reg;
    logic        skip_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [NUM_SPEEDS*SPEED_W-1:0] out_data_reg;
    logic [NUM_SPEEDS*SPEED_W-1:0] out_data_next;

    logic        s_accept;
    logic        live_byte;
    logic        is_close;
    logic        is_abort;
    logic        is_open;
    logic        emit;
    cell_ctrl_t  ctrl;

    logic [7:0]            cell_byte   [KEPT_BYTES];
    logic [KEPT_BYTES-1:0] cell_filled;
    logic [KEPT_BYTES:0]   chain_filled;
    logic [SPEED_W-1:0]    speed       [NUM_SPEEDS];

    assign s_tready  = !out_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign live_byte = s_accept && (action_t'(s_tuser) == ACT_BYTE) && !skip_reg;
    assign is_close  = s_tdata == CH_CLOSE;
    assign is_abort  = s_tdata == CH_ABORT;
    assign is_open   = (s_tdata == CH_OPEN_A) || (s_tdata == CH_OPEN_B);

    assign ctrl.clear = live_byte && (is_close || is_abort);
    assign ctrl.store = live_byte && !is_close && !is_abort && in_frame_reg;

    assign emit = live_byte && is_close && (cell_byte[0] == wheel_code_reg);

    // Cell chain: each cell fills after its left neighbor.
    assign chain_filled[0] = 1'b1;

    for (genvar i = 0; i < KEPT_BYTES; i++) begin : g_cell
        wspf_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .byte_in     (s_tdata),
            .prev_filled (chain_filled[i]),
            .byte_q      (cell_byte[i]),
            .filled_q    (cell_filled[i])
        );
        assign chain_filled[i+1] = cell_filled[i];
    end

    for (genvar k = 0; k < NUM_SPEEDS; k++) begin : g_speed
        wspf_speed u_speed (
            .hi_byte   (cell_byte[2*k+1]),
            .lo_byte   (cell_byte[2*k+2]),
            .threshold (threshold_reg),
            .speed     (speed[k])
        );
    end

    always_comb begin
        in_frame_next = in_frame_reg;
        skip_next     = skip_reg;
        if (s_accept && (action_t'(s_tuser) == ACT_IDLE)) begin
            skip_next = 1'b0;
        end else if (live_byte) begin
            if (is_close || is_abort) begin
                in_frame_next = 1'b0;
                skip_next     = 1'b1;
            end else if (is_open) begin
                in_frame_next = 1'b1;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (emit) begin
            out_valid_next = 1'b1;
            out_data_next  = {speed[3], speed[2], speed[1], speed[0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheel_code_reg <= WHEEL_CODE_RST;
            threshold_reg  <= THRESH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                REG_WHEEL_CODE: wheel_code_reg <= cfg_data[7:0];
                REG_THRESHOLD:  threshold_reg  <= cfg_data;
                default:        threshold_reg  <= threshold_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg  <= 1'b0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_frame_reg  <= in_frame_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - NUM_SPEEDS*SPEED_W){1'b0}}, out_data_reg};

`ifndef NO_ASSERTIONS
    a_fill_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        ((cell_filled >> 1) & ~cell_filled) == '0)
        else $error("cell chain filled out of order");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.clear |=> (cell_filled == '0) && !in_frame_reg && skip_reg)
        else $error("frame not cleared after close or abort");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_accept) && $past(s_tdata) == CH_CLOSE)
        else $error("result without a closing byte");

    a_no_store_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        skip_reg |-> !ctrl.store)
        else $error("byte stored while skipping to idle");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/wspf_cell.sv
// One byte cell of the frame buffer chain.
// Takes the byte when its neighbor is filled and it is not; uses wspf_pkg.
`default_nettype none

module wspf_cell (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wspf_pkg::cell_ctrl_t ctrl,
    input  wire  [7:0]           byte_in,
    input  wire                  prev_filled,
    output logic [7:0]           byte_q,
    output logic                 filled_q
);
    import wspf_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       filled_reg;
    logic       filled_next;
    logic       take;

    assign take = ctrl.store && prev_filled && !filled_reg;

    always_comb begin
        byte_next   = byte_reg;
        filled_next = filled_reg;
        if (ctrl.clear) begin
            byte_next   = 8'd0;
            filled_next = 1'b0;
        end else if (take) begin
            byte_next   = byte_in;
            filled_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg   <= 8'd0;
            filled_reg <= 1'b0;
        end else begin
            byte_reg   <= byte_next;
            filled_reg <= filled_next;
        end
    end

    assign byte_q   = byte_reg;
    assign filled_q = filled_reg;

endmodule

`default_nettype wire

>>> hw/rtl/wspf_speed.sv
// Speed decode: big-endian 16-bit raw value, wrapped negative above threshold.
// Combinational; uses wspf_pkg.
`default_nettype none

module wspf_speed (
    input  wire  [7:0]                      hi_byte,
    input  wire  [7:0]                      lo_byte,
    input  wire  [15:0]                     threshold,
    output logic [wspf_pkg::SPEED_W-1:0]    speed
);
    import wspf_pkg::*;

    logic [15:0] raw;

    assign raw = {hi_byte, lo_byte};

    always_comb begin
        if (raw > threshold) begin
            speed = {1'b0, raw} - SIGN_OFFSET;
        end else begin
            speed = {1'b0, raw};
        end
    end

endmodule

`default_nettype wire

>>> sim/wspf_speed_checker.sv
// Checker for the wheel speed frame parser: tracks register writes, predicts the
// decoded speeds for each accepted input transaction and compares them with m_tdata.
// Depends on wspf_pkg.
`timescale 1ns / 100ps

module wspf_speed_checker
    import wspf_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire         cfg_index,
    input  wire  [15:0] cfg_data,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [7:0]  s_tdata,
    input  wire         s_tuser,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [71:0] m_tdata,
    output int          mismatches,
    output int          pending
);

    localparam int BUFFER_DEPTH = 40;

    logic [7:0]  wheel_code;
    logic [15:0] threshold;
    logic [7:0]  frame_buf [KEPT_BYTES];
    int          fill;
    logic        frame_open;
    logic        skip_bytes;

    // {speed_four, speed_three, speed_two, speed_one}, same layout as m_tdata
    logic [67:0] speeds_due [$];

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    function automatic logic [16:0] to_speed(logic [7:0] hi, logic [7:0] lo);
        logic [16:0] raw;
        raw = {1'b0, hi, lo};
        if (raw[15:0] > threshold) begin
            raw = raw - SIGN_OFFSET;
        end
        return raw;
    endfunction

    task automatic clear_frame();
        for (int i = 0; i < KEPT_BYTES; i++) begin
            frame_buf[i] = 8'h00;
        end
        fill       = 0;
        frame_open = 1'b0;
    endtask

    task automatic predict_transaction(action_t act, logic [7:0] b);
        if (act == ACT_IDLE) begin
            skip_bytes = 1'b0;
            return;
        end
        if (skip_bytes) begin
            return;
        end
        if (b == CH_CLOSE || b == CH_ABORT) begin
            if (b == CH_CLOSE && frame_buf[0] == wheel_code) begin
                speeds_due.push_back({to_speed(frame_buf[7], frame_buf[8]),
                                      to_speed(frame_buf[5], frame_buf[6]),
                                      to_speed(frame_buf[3], frame_buf[4]),
                                      to_speed(frame_buf[1], frame_buf[2])});
            end
            clear_frame();
            skip_bytes = 1'b1;
            return;
        end
        if (frame_open && fill < BUFFER_DEPTH) begin
            if (fill < KEPT_BYTES) begin
                frame_buf[fill] = b;
            end
            fill++;
        end
        if (b == CH_OPEN_A || b == CH_OPEN_B) begin
            frame_open = 1'b1;
        end
    endtask

    task automatic check_speed(string name, logic [16:0] exp_v, logic [16:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, actual %0d", name, $signed(exp_v), $signed(act_v));
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        logic [67:0] want;
        if (!aresetn) begin
            wheel_code = WHEEL_CODE_RST;
            threshold  = THRESH_RST;
            clear_frame();
            skip_bytes = 1'b0;
            speeds_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_index))
                    REG_WHEEL_CODE: wheel_code = cfg_data[7:0];
                    REG_THRESHOLD:  threshold  = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (speeds_due.size() == 0) begin
                    $error("unexpected result transaction: m_tdata = %h", m_tdata);
                    mismatches++;
                end else begin
                    want = speeds_due.pop_front();
                    check_speed("speed_one",   want[16:0],  m_tdata[16:0]);
                    check_speed("speed_two",   want[33:17], m_tdata[33:17]);
                    check_speed("speed_three", want[50:34], m_tdata[50:34]);
                    check_speed("speed_four",  want[67:51], m_tdata[67:51]);
                end
            end
            if (s_tvalid && s_tready) begin
                predict_transaction(action_t'(s_tuser), s_tdata);
            end
        end
        pending = speeds_due.size();
    end

endmodule

>>> sim/tb_wheel_speed_frame_parser.sv
// Testbench top for the wheel speed frame parser: clock, reset, byte/idle stimulus,
// register phases and the verdict. Depends on wspf_pkg, the parser RTL and
// wspf_speed_checker.
`timescale 1ns / 100ps

module tb_wheel_speed_frame_parser;
    import wspf_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASE_ITEMS = 95;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    cfg_index_t  cfg_index = REG_WHEEL_CODE;
    logic [15:0] cfg_data  = 16'h0000;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    action_t     s_tuser   = ACT_BYTE;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;

    int          mismatches;
    int          pending;
    int          sent = 0;
    int          burst_left = 0;
    logic [7:0]  cur_code = WHEEL_CODE_RST;
    logic [15:0] cur_thresh = THRESH_RST;
    logic [11:0] rx_cycle = '0;
    int          rx_hold = 0;

    wheel_speed_frame_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    wspf_speed_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // receiver: random stalls, with stall-free stretches while rx_cycle[11] is set
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1'b1;
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else if (rx_cycle[11] == 1'b0 && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            rx_hold  <= $urandom_range(0, 12);
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [7:0] data_byte(logic [7:0] b);
        return (b == CH_CLOSE || b == CH_ABORT) ? (b ^ 8'h01) : b;
    endfunction

    task automatic send_txn(action_t act, logic [7:0] b);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(0, 30);
        end
    endtask

    task automatic send_byte(logic [7:0] b);
        send_txn(ACT_BYTE, b);
    endtask

    task automatic send_idle();
        send_txn(ACT_IDLE, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(logic [7:0] code, logic [15:0] thresh);
        drain_results();
        write_reg(REG_WHEEL_CODE, {8'h00, code});
        write_reg(REG_THRESHOLD, thresh);
        cur_code   = code;
        cur_thresh = thresh;
    endtask

    // one frame with random content, mostly well formed
    task automatic send_frame();
        logic [7:0] pay [$];
        logic [15:0] v;
        int plen;
        int near;
        int sel;
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        end
        sel = $urandom_range(0, 9);
        plen = (sel < 8) ? 8 : (sel == 8) ? $urandom_range(0, 7) : $urandom_range(9, 48);
        for (int k = 0; k < (plen + 1) / 2; k++) begin
            case ($urandom_range(0, 3))
                0: v = 16'($urandom_range(0, 65535));
                1: begin
                    near = int'(cur_thresh) + $urandom_range(0, 4) - 2;
                    v = (near < 0) ? 16'h0000 : (near > 65535) ? 16'hFFFF : 16'(near);
                end
                2: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                default: v = 16'($urandom_range(0, 300));
            endcase
            pay.push_back(data_byte(v[15:8]));
            pay.push_back(data_byte(v[7:0]));
        end
        send_byte($urandom_range(0, 1) ? CH_OPEN_A : CH_OPEN_B);
        send_byte(($urandom_range(0, 4) != 0) ? data_byte(cur_code)
                                               : data_byte(8'($urandom_range(0, 255))));
        for (int k = 0; k < plen; k++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_idle();
            end
            send_byte(pay[k]);
        end
        sel = $urandom_range(0, 19);
        if (sel < 17) begin
            send_byte(CH_CLOSE);
        end else if (sel < 19) begin
            send_byte(CH_ABORT);
        end
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) != 0) begin
            send_idle();
        end
    endtask

    task automatic run_phase(int items);
        int stop_at;
        stop_at = sent + items;
        while (sent < stop_at) begin
            if ($urandom_range(0, 6) == 0) begin
                send_txn(action_t'($urandom_range(0, 3) == 0),
                         8'($urandom_range(0, 255)));
            end else begin
                send_frame();
            end
            if ($urandom_range(0, 29) == 0) begin
                drain_results();
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: threshold edges, skip after close, lone close, other type,
        // short frame with an opening byte inside and a chunk break
        send_idle();
        send_byte(CH_OPEN_A);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h4E);
        send_byte(8'h20);
        send_byte(8'h4E);
        send_byte(8'h21);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(CH_CLOSE);
        send_byte(CH_OPEN_A);
        send_idle();
        send_byte(CH_CLOSE);
        send_idle();
        send_byte(CH_OPEN_B);
        send_byte(8'h05);
        send_byte(CH_CLOSE);
        send_idle();
        send_byte(CH_OPEN_A);
        send_byte(8'h01);
        send_byte(CH_OPEN_B);
        send_byte(8'h34);
        send_idle();
        send_byte(CH_CLOSE);

        run_phase(PHASE_ITEMS);

        set_config(8'h00, 16'h0000);
        send_idle();
        send_byte(CH_CLOSE);
        run_phase(PHASE_ITEMS);

        set_config(8'hFF, 16'hFFFF);
        run_phase(PHASE_ITEMS);

        set_config(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        run_phase(PHASE_ITEMS);

        set_config(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        run_phase(PHASE_ITEMS);

        set_config(8'h01, 16'h7FFF);
        run_phase(PHASE_ITEMS);

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
